FILE: hdl/tts_pkg.sv
// Shared types and constants of the trade tick summary aggregator.
// Depends on nothing; tts_datapath, tts_ctrl, the top level and the testbench import it.
package tts_pkg;

   // Default size of the status bucket table.
   localparam int STATUS_SLOTS_DEFAULT = 8;
   // Number of fixed statistics ahead of the bucket words in a run.
   localparam int FIXED_STATS = 18;

   // Statistic kinds of a result word.
   localparam logic [4:0] KIND_TICKS      = 5'd0;
   localparam logic [4:0] KIND_FIRST      = 5'd1;
   localparam logic [4:0] KIND_HIGH       = 5'd2;
   localparam logic [4:0] KIND_LOW        = 5'd3;
   localparam logic [4:0] KIND_LAST       = 5'd4;
   localparam logic [4:0] KIND_VOLUME     = 5'd5;
   localparam logic [4:0] KIND_ORDERS     = 5'd6;
   localparam logic [4:0] KIND_AMOUNT     = 5'd7;
   localparam logic [4:0] KIND_BUY_VOL    = 5'd8;
   localparam logic [4:0] KIND_BUY_AMT    = 5'd9;
   localparam logic [4:0] KIND_SELL_VOL   = 5'd10;
   localparam logic [4:0] KIND_SELL_AMT   = 5'd11;
   localparam logic [4:0] KIND_NEUT_VOL   = 5'd12;
   localparam logic [4:0] KIND_NEUT_AMT   = 5'd13;
   localparam logic [4:0] KIND_MINUTES    = 5'd14;
   localparam logic [4:0] KIND_FIRST_TIME = 5'd15;
   localparam logic [4:0] KIND_LAST_TIME  = 5'd16;
   localparam logic [4:0] KIND_VWAP       = 5'd17;
   localparam logic [4:0] KIND_BUCKET     = 5'd18;

   // Side codes that have their own sums.
   localparam logic [15:0] SIDE_BUY     = 16'd0;
   localparam logic [15:0] SIDE_SELL    = 16'd1;
   localparam logic [15:0] SIDE_NEUTRAL = 16'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } tts_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic accum;
      logic div_start;
      logic emit_next;
      logic clear;
   } tts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_tick;
      logic div_done;
      logic run_end;
   } tts_status_type;

endpackage

FILE: hdl/tts_if.sv
// Valid/ready channel interfaces for tick words and result words.
// Depends on nothing.
interface tts_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] price_raw;
   logic [31:0] volume_hands;
   logic [23:0] orders;
   logic [15:0] side_code;
   logic [10:0] minute_of_day;
   logic        end_of_series;

   modport source (output valid, price_raw, volume_hands, orders, side_code,
                   minute_of_day, end_of_series, input ready);
   modport sink (input valid, price_raw, volume_hands, orders, side_code,
                 minute_of_day, end_of_series, output ready);
endinterface

interface tts_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  stat_kind;
   logic [15:0] stat_key;
   logic [63:0] stat_value;
   logic        run_last;

   modport source (output valid, stat_kind, stat_key, stat_value, run_last,
                   input ready);
   modport sink (input valid, stat_kind, stat_key, stat_value, run_last,
                 output ready);
endinterface

FILE: hdl/tts_divider.sv
// Restoring 64-bit by 64-bit unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module tts_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic [63:0] quotient,
   output logic        done
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic        ge;

   // One shift, compare and subtract step. The remainder always stays below
   // the divisor, so it fits in 64 bits after the subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      ge = (shifted >= {1'b0, div_ff});
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? 64'(shifted - {1'b0, div_ff}) : shifted[63:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags take reset; the operands do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;
   assign done = done_ff;
endmodule

FILE: hdl/tts_datapath.sv
// Accumulators, sorted status table, VWAP divider and result word select.
// Depends on tts_pkg and tts_divider.
module tts_datapath #(
   parameter int STATUS_SLOTS = tts_pkg::STATUS_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tts_pkg::tts_cmd_type  cmd,
   output tts_pkg::tts_status_type status,
   input  logic [31:0]           price_raw,
   input  logic [31:0]           volume_hands,
   input  logic [23:0]           orders,
   input  logic [15:0]           side_code,
   input  logic [10:0]           minute_of_day,
   input  logic                  end_of_series,
   output logic [4:0]            stat_kind,
   output logic [15:0]           stat_key,
   output logic [63:0]           stat_value,
   output logic                  run_last
);
   import tts_pkg::*;

   localparam int UW = $clog2(STATUS_SLOTS + 1);
   localparam int IW = (STATUS_SLOTS > 1) ? $clog2(STATUS_SLOTS) : 1;
   localparam int RUN_MAX = FIXED_STATS + STATUS_SLOTS;
   localparam int XW = $clog2(RUN_MAX + 1);

   // Captured tick and its amount.
   logic [31:0] price_ff, vol_ff;
   logic [23:0] ord_ff;
   logic [15:0] side_ff;
   logic [10:0] minute_ff;
   logic        last_ff;
   logic [63:0] amt_ff;

   // Summary state.
   logic        have_price_ff;
   logic [31:0] first_ff, high_ff, low_ff, latest_ff, ticks_ff, changes_ff;
   logic [63:0] volume_ff, orders_ff, amount_ff;
   logic [63:0] side_vol_ff [3];
   logic [63:0] side_amt_ff [3];
   logic        prev_valid_ff;
   logic [10:0] prev_minute_ff, first_minute_ff;
   logic [15:0] key_ff [STATUS_SLOTS];
   logic [31:0] count_ff [STATUS_SLOTS];
   logic [15:0] key_in [STATUS_SLOTS];
   logic [31:0] count_in [STATUS_SLOTS];
   logic [UW-1:0] used_ff;
   logic [XW-1:0] idx_ff;

   logic [STATUS_SLOTS-1:0] match, less;
   logic [UW-1:0] ins_pos;
   logic [IW-1:0] hit_idx;
   logic [63:0] quotient;
   logic        div_done;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] a);
      return (a == {32{1'b1}}) ? a : a + 32'd1;
   endfunction

   // Parallel compare of the tick's status against every table entry.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < STATUS_SLOTS; i++) begin
         match[i] = (UW'(i) < used_ff) && (key_ff[i] == side_ff);
         less[i] = (UW'(i) < used_ff) && (key_ff[i] < side_ff);
         if (match[i]) hit_idx = IW'(i);
      end
      ins_pos = UW'($countones(less));
   end

   // Table update: bump a hit, or while room remains insert in order, shifting larger keys up.
   always_comb begin
      for (int i = 0; i < STATUS_SLOTS; i++) begin
         key_in[i] = key_ff[i];
         count_in[i] = count_ff[i];
         if (|match) begin
            if (IW'(i) == hit_idx) count_in[i] = sat_inc(count_ff[i]);
         end else if (used_ff < UW'(STATUS_SLOTS)) begin
            if (UW'(i) == ins_pos) begin
               key_in[i] = side_ff;
               count_in[i] = 32'd1;
            end else if ((UW'(i) > ins_pos) && (i > 0)) begin
               key_in[i] = key_ff[(i > 0) ? i - 1 : 0];
               count_in[i] = count_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   // Capture the tick with its price times volume product.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         price_ff <= price_raw;
         vol_ff <= volume_hands;
         ord_ff <= orders;
         side_ff <= side_code;
         minute_ff <= minute_of_day;
         last_ff <= end_of_series;
         amt_ff <= {32'b0, price_raw} * {32'b0, volume_hands};
      end
   end

   // Table entries have no reset; only the fill count marks them.
   always_ff @(posedge clock) begin
      if (cmd.accum) begin
         for (int i = 0; i < STATUS_SLOTS; i++) begin
            key_ff[i] <= key_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   // Accumulate on a tick; clear after the run.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         have_price_ff <= 1'b0;
         first_ff <= '0;
         high_ff <= '0;
         low_ff <= '0;
         latest_ff <= '0;
         ticks_ff <= '0;
         volume_ff <= '0;
         orders_ff <= '0;
         amount_ff <= '0;
         for (int s = 0; s < 3; s++) begin
            side_vol_ff[s] <= '0;
            side_amt_ff[s] <= '0;
         end
         changes_ff <= '0;
         prev_valid_ff <= 1'b0;
         prev_minute_ff <= '0;
         first_minute_ff <= '0;
         used_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (cmd.accum) begin
            if (!have_price_ff) begin
               first_ff <= price_ff;
               high_ff <= price_ff;
               low_ff <= price_ff;
               have_price_ff <= 1'b1;
            end else begin
               if (price_ff > high_ff) high_ff <= price_ff;
               if (price_ff < low_ff) low_ff <= price_ff;
            end
            latest_ff <= price_ff;
            ticks_ff <= sat_inc(ticks_ff);
            volume_ff <= sat_add(volume_ff, {32'b0, vol_ff});
            orders_ff <= sat_add(orders_ff, {40'b0, ord_ff});
            amount_ff <= sat_add(amount_ff, amt_ff);
            for (int s = 0; s < 3; s++) begin
               if (side_ff == 16'(s)) begin
                  side_vol_ff[s] <= sat_add(side_vol_ff[s], {32'b0, vol_ff});
                  side_amt_ff[s] <= sat_add(side_amt_ff[s], amt_ff);
               end
            end
            if (!prev_valid_ff) begin
               first_minute_ff <= minute_ff;
               changes_ff <= sat_inc(changes_ff);
            end else if (prev_minute_ff != minute_ff) begin
               changes_ff <= sat_inc(changes_ff);
            end
            prev_minute_ff <= minute_ff;
            prev_valid_ff <= 1'b1;
            if (!(|match) && (used_ff < UW'(STATUS_SLOTS))) used_ff <= used_ff + UW'(1);
         end
         if (cmd.emit_next) idx_ff <= idx_ff + XW'(1);
      end
   end

   tts_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (amount_ff),
      .divisor  (volume_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   // Result word select from the emission index.
   logic [4:0]  kind_sel;
   logic [XW-1:0] bidx;
   always_comb begin
      kind_sel = (idx_ff < XW'(FIXED_STATS)) ? idx_ff[4:0] : KIND_BUCKET;
      bidx = idx_ff - XW'(FIXED_STATS);
      stat_key = '0;
      case (kind_sel)
         KIND_TICKS:      stat_value = {32'b0, ticks_ff};
         KIND_FIRST:      stat_value = {32'b0, first_ff};
         KIND_HIGH:       stat_value = {32'b0, high_ff};
         KIND_LOW:        stat_value = {32'b0, low_ff};
         KIND_LAST:       stat_value = {32'b0, latest_ff};
         KIND_VOLUME:     stat_value = volume_ff;
         KIND_ORDERS:     stat_value = orders_ff;
         KIND_AMOUNT:     stat_value = amount_ff;
         KIND_BUY_VOL:    stat_value = side_vol_ff[0];
         KIND_BUY_AMT:    stat_value = side_amt_ff[0];
         KIND_SELL_VOL:   stat_value = side_vol_ff[1];
         KIND_SELL_AMT:   stat_value = side_amt_ff[1];
         KIND_NEUT_VOL:   stat_value = side_vol_ff[2];
         KIND_NEUT_AMT:   stat_value = side_amt_ff[2];
         KIND_MINUTES:    stat_value = {32'b0, changes_ff};
         KIND_FIRST_TIME: stat_value = {53'b0, first_minute_ff};
         KIND_LAST_TIME:  stat_value = {53'b0, prev_minute_ff};
         KIND_VWAP:       stat_value = (volume_ff == '0) ? '0 : quotient;
         KIND_BUCKET: begin
            stat_key = key_ff[bidx[IW-1:0]];
            stat_value = {32'b0, count_ff[bidx[IW-1:0]]};
         end
         default:         stat_value = '0;
      endcase
      stat_kind = kind_sel;
      run_last = (idx_ff == (XW'(FIXED_STATS) + XW'(used_ff) - XW'(1)));
   end

   assign status.last_tick = last_ff;
   assign status.div_done = div_done;
   assign status.run_end = run_last;
endmodule

FILE: hdl/tts_ctrl.sv
// Controller state machine: tick intake, accumulation, divide and run output.
// Depends on tts_pkg.
module tts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tts_pkg::tts_status_type status,
   output tts_pkg::tts_cmd_type   cmd
);
   import tts_pkg::*;

   tts_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_ACC;
         ST_ACC:      state_in = status.last_tick ? ST_DIV_GO : ST_IDLE;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (status.div_done) state_in = ST_EMIT;
         ST_EMIT:     if (rsp_ready && status.run_end) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_ACC:      cmd.accum = 1'b1;
         ST_DIV_GO:   cmd.div_start = 1'b1;
         ST_DIV_WAIT: ;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit_next = rsp_ready && !status.run_end;
            cmd.clear = rsp_ready && status.run_end;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

FILE: hdl/trade_tick_summary_aggregator.sv
// Top level of the trade tick summary aggregator.
// Depends on tts_pkg, tts_if, tts_ctrl and tts_datapath.
//
// Usage: tick words enter on req_ch (valid/ready). Each word carries price,
// volume, order count, side status, minute of day and an end-of-series flag.
// To absorb a tick, the accept cycle registers the tick and
// its 32x32 price times volume product, the next cycle updates all sums and
// the sorted status table. A tick without the end flag yields no result.
// A tick with the end flag starts a summary run on rsp_ch. After the
// accumulate cycle the controller starts the VWAP divider, which makes
// one quotient bit per cycle, waits until the divider reports done and
// only then presents the first word of the summary run on rsp_ch.
// Then come 18 fixed statistic words and one word per status bucket in
// ascending status order, one word per cycle while the receiver takes them.
// run_last marks the final word; after it the state is cleared and the
// next tick is taken in the following cycle. While the receiver stalls, the
// current word holds and no tick is taken. Reset is synchronous and leaves
// the block empty and ready for a tick in the next cycle.
module trade_tick_summary_aggregator #(
   parameter int STATUS_SLOTS = tts_pkg::STATUS_SLOTS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   tts_req_if.sink  req_ch,
   tts_rsp_if.source rsp_ch
);
   import tts_pkg::*;

   tts_cmd_type    cmd;
   tts_status_type status;

   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tts_datapath #(.STATUS_SLOTS(STATUS_SLOTS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .price_raw     (req_ch.price_raw),
      .volume_hands  (req_ch.volume_hands),
      .orders        (req_ch.orders),
      .side_code     (req_ch.side_code),
      .minute_of_day (req_ch.minute_of_day),
      .end_of_series (req_ch.end_of_series),
      .stat_kind     (rsp_ch.stat_kind),
      .stat_key      (rsp_ch.stat_key),
      .stat_value    (rsp_ch.stat_value),
      .run_last      (rsp_ch.run_last)
   );

   // No tick is taken while a run is being delivered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("tick accepted during a summary run");

   // A tick occupies the block for the cycle after its accept.
   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("tick accepted before the previous one was absorbed");

   // The run ends with its final word.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.run_last) |=> !rsp_ch.valid)
      else $error("result word after the end of a run");
endmodule

FILE: test/trade_tick_summary_aggregator_tb.sv
// Testbench of the trade tick summary aggregator: directed and random tick series.
// Depends on tts_pkg, tts_if and trade_tick_summary_aggregator; a behavioral
// predictor computes each summary run and a monitor checks every result word.
module trade_tick_summary_aggregator_tb;
   import tts_pkg::*;

   localparam int SLOTS = STATUS_SLOTS_DEFAULT;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [31:0] price;
      logic [31:0] volume;
      logic [23:0] orders;
      logic [15:0] side;
      logic [10:0] minute;
      logic        last;
   } tick_word_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] key;
      logic [63:0] value;
      logic        run_last;
   } stat_word_type;

   logic clock;
   logic reset;
   tts_req_if req_ch ();
   tts_rsp_if rsp_ch ();

   trade_tick_summary_aggregator dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   tick_word_type pending_ticks[$];
   stat_word_type expected_stats[$];
   int         error_count = 0;
   int         cycle_count = 0;
   logic       stimulus_done = 1'b0;

   // Predictor state of the running series.
   logic        have_price;
   logic [31:0] open_price, peak_price, floor_price, latest_price, tick_total;
   logic [63:0] volume_total, order_total, amount_total;
   logic [63:0] side_volume[3];
   logic [63:0] side_amount[3];
   logic [31:0] minute_changes;
   logic        prev_minute_valid;
   logic [10:0] prev_minute, first_minute;
   logic [15:0] bucket_status[SLOTS];
   logic [31:0] bucket_count[SLOTS];
   int          buckets_used;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? MAX64 : s[63:0];
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] a);
      return (a == MAX32) ? MAX32 : a + 32'd1;
   endfunction

   task automatic clear_series();
      have_price = 0;
      open_price = 0;
      peak_price = 0;
      floor_price = 0;
      latest_price = 0;
      tick_total = 0;
      volume_total = 0;
      order_total = 0;
      amount_total = 0;
      for (int i = 0; i < 3; i++) begin
         side_volume[i] = 0;
         side_amount[i] = 0;
      end
      minute_changes = 0;
      prev_minute_valid = 0;
      prev_minute = 0;
      first_minute = 0;
      buckets_used = 0;
   endtask

   task automatic push_stat(input logic [4:0] kind, input logic [15:0] key,
                            input logic [63:0] value);
      stat_word_type w;
      w.kind = kind;
      w.key = key;
      w.value = value;
      w.run_last = 1'b0;
      expected_stats.push_back(w);
   endtask

   // Absorbs one accepted tick and queues the summary run on the end flag.
   task automatic absorb_tick(input tick_word_type t);
      logic [63:0] amt;
      logic [15:0] ks[SLOTS];
      logic [31:0] cs[SLOTS];
      logic [15:0] tk;
      logic [31:0] tc;
      stat_word_type w;
      int          hit;
      amt = {32'd0, t.price} * {32'd0, t.volume};
      if (!have_price) begin
         open_price = t.price;
         peak_price = t.price;
         floor_price = t.price;
         have_price = 1;
      end else begin
         if (t.price > peak_price) peak_price = t.price;
         if (t.price < floor_price) floor_price = t.price;
      end
      latest_price = t.price;
      tick_total = sat_inc(tick_total);
      volume_total = sat_add(volume_total, {32'd0, t.volume});
      order_total = sat_add(order_total, {40'd0, t.orders});
      amount_total = sat_add(amount_total, amt);
      if (t.side < 16'd3) begin
         side_volume[t.side] = sat_add(side_volume[t.side], {32'd0, t.volume});
         side_amount[t.side] = sat_add(side_amount[t.side], amt);
      end
      if (!prev_minute_valid) begin
         first_minute = t.minute;
         minute_changes = sat_inc(minute_changes);
      end else if (prev_minute != t.minute) begin
         minute_changes = sat_inc(minute_changes);
      end
      prev_minute = t.minute;
      prev_minute_valid = 1;

      // Status table: count a known code, add a new one while room remains.
      hit = -1;
      for (int i = 0; i < buckets_used; i++)
         if (hit < 0 && bucket_status[i] == t.side) hit = i;
      if (hit >= 0) begin
         bucket_count[hit] = sat_inc(bucket_count[hit]);
      end else if (buckets_used < SLOTS) begin
         bucket_status[buckets_used] = t.side;
         bucket_count[buckets_used] = 1;
         buckets_used++;
      end
      if (!t.last) return;

      push_stat(KIND_TICKS, 0, {32'd0, tick_total});
      push_stat(KIND_FIRST, 0, {32'd0, open_price});
      push_stat(KIND_HIGH, 0, {32'd0, peak_price});
      push_stat(KIND_LOW, 0, {32'd0, floor_price});
      push_stat(KIND_LAST, 0, {32'd0, latest_price});
      push_stat(KIND_VOLUME, 0, volume_total);
      push_stat(KIND_ORDERS, 0, order_total);
      push_stat(KIND_AMOUNT, 0, amount_total);
      push_stat(KIND_BUY_VOL, 0, side_volume[0]);
      push_stat(KIND_BUY_AMT, 0, side_amount[0]);
      push_stat(KIND_SELL_VOL, 0, side_volume[1]);
      push_stat(KIND_SELL_AMT, 0, side_amount[1]);
      push_stat(KIND_NEUT_VOL, 0, side_volume[2]);
      push_stat(KIND_NEUT_AMT, 0, side_amount[2]);
      push_stat(KIND_MINUTES, 0, {32'd0, minute_changes});
      push_stat(KIND_FIRST_TIME, 0, {53'd0, first_minute});
      push_stat(KIND_LAST_TIME, 0, {53'd0, prev_minute});
      push_stat(KIND_VWAP, 0, (volume_total == 0) ? 64'd0 : amount_total / volume_total);

      // Buckets leave in ascending status order.
      for (int a = 0; a < buckets_used; a++) begin
         ks[a] = bucket_status[a];
         cs[a] = bucket_count[a];
      end
      for (int a = 0; a + 1 < buckets_used; a++)
         for (int b = a + 1; b < buckets_used; b++)
            if (ks[b] < ks[a]) begin
               tk = ks[a]; ks[a] = ks[b]; ks[b] = tk;
               tc = cs[a]; cs[a] = cs[b]; cs[b] = tc;
            end
      for (int a = 0; a < buckets_used; a++)
         push_stat(KIND_BUCKET, ks[a], {32'd0, cs[a]});
      w = expected_stats.pop_back();
      w.run_last = 1'b1;
      expected_stats.push_back(w);
      clear_series();
   endtask

   function automatic tick_word_type make_tick(input logic [31:0] p, input logic [31:0] v,
                                               input logic [23:0] o, input logic [15:0] s,
                                               input logic [10:0] m, input logic l);
      tick_word_type t;
      t.price = p;
      t.volume = v;
      t.orders = o;
      t.side = s;
      t.minute = m;
      t.last = l;
      return t;
   endfunction

   // Random tick; side codes lean to the three sides and a small code set.
   function automatic tick_word_type random_tick(input logic l);
      logic [31:0] p, v;
      logic [15:0] s;
      logic [10:0] m;
      case ($urandom_range(0, 3))
         0: p = $urandom;
         1: p = MAX32 - $urandom_range(0, 3);
         default: p = $urandom_range(0, 100000);
      endcase
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = 0;
         default: v = $urandom_range(0, 5000);
      endcase
      case ($urandom_range(0, 3))
         0: s = 16'($urandom);
         1: s = 16'($urandom_range(3, 12));
         default: s = 16'($urandom_range(0, 2));
      endcase
      m = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1439));
      return make_tick(p, v, 24'($urandom), s, m, l);
   endfunction

   // Stimulus: directed series first, then random series of varied length.
   initial begin
      int len;
      int total;
      clear_series();
      pending_ticks.push_back(make_tick(0, 0, 0, SIDE_BUY, 0, 1));
      pending_ticks.push_back(make_tick(MAX32, MAX32, 24'hFFFFFF, SIDE_SELL, 11'd2047, 0));
      pending_ticks.push_back(make_tick(MAX32, MAX32, 24'hFFFFFF, SIDE_SELL, 11'd2047, 0));
      pending_ticks.push_back(make_tick(MAX32, MAX32, 24'hFFFFFF, 16'hFFFF, 11'd1439, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, SIDE_NEUTRAL, 11'd1439, 1));
      // Ten distinct codes overflow the table; minutes repeat and change.
      for (int i = 0; i < 10; i++)
         pending_ticks.push_back(make_tick(32'd100 + i * 7, 32'd10 - i, 24'(i),
                                           16'(9 - i), 11'(i / 3), i == 9));
      pending_ticks.push_back(make_tick(32'h5555_AAAA, 32'hAAAA_5555, 24'h555555,
                                        16'h5555, 11'h2AA, 0));
      pending_ticks.push_back(make_tick(32'hAAAA_5555, 32'h5555_AAAA, 24'hAAAAAA,
                                        16'hAAAA, 11'h555, 1));
      total = 0;
      while (total < 500) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++)
            pending_ticks.push_back(random_tick(i == len - 1));
         total += len;
      end
      stimulus_done = 1'b1;
   end

   // Driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         {req_ch.price_raw, req_ch.volume_hands, req_ch.orders, req_ch.side_code,
          req_ch.minute_of_day, req_ch.end_of_series} <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            absorb_tick(pending_ticks.pop_front());
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               req_ch.valid <= 1'b1;
               {req_ch.price_raw, req_ch.volume_hands, req_ch.orders, req_ch.side_code,
                req_ch.minute_of_day, req_ch.end_of_series} <= pending_ticks[0];
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness: long ready stretches broken by stall bursts.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 2) begin
         stall_left = $urandom_range(0, 6);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: every accepted result word is checked against the oldest expectation.
   always @(posedge clock) begin
      stat_word_type want;
      stat_word_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.stat_kind, rsp_ch.stat_key, rsp_ch.stat_value, rsp_ch.run_last};
         if (expected_stats.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $realtime, got);
            error_count++;
         end else begin
            want = expected_stats.pop_front();
            if (got.kind !== want.kind) begin
               $display("%0t: stat_kind expected %0d actual %0d", $realtime,
                        want.kind, got.kind);
               error_count++;
            end
            if (got.key !== want.key) begin
               $display("%0t: stat_key expected %h actual %h", $realtime, want.key, got.key);
               error_count++;
            end
            if (got.value !== want.value) begin
               $display("%0t: stat_value (kind %0d) expected %h actual %h", $realtime,
                        want.kind, want.value, got.value);
               error_count++;
            end
            if (got.run_last !== want.run_last) begin
               $display("%0t: run_last expected %b actual %b", $realtime,
                        want.run_last, got.run_last);
               error_count++;
            end
         end
      end
   end

   // Cycle limit covering every run with maximal stalls.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      while (pending_ticks.size() > 0 || req_ch.valid || expected_stats.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_stats.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
